FILE: rtl/core/cdq_pkg.sv
// Shared types and codes for the circular deque.
package cdq_pkg;

    // Request codes
    localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
    localparam logic [1:0] REQ_PUSH_REAR  = 2'd1;
    localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
    localparam logic [1:0] REQ_POP_REAR   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    // Capacity register
    localparam int         CAP_W     = 5;
    localparam logic [4:0] CAP_RESET = 5'd16;

    // Item word width
    localparam int DATA_W = 32;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic exec;    // carry out the request presented on the input ports
        logic cfg_wr;  // load capacity and empty the deque
    } t_dp_cmd;

endpackage

FILE: rtl/core/cdq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/cdq_ctrl.sv
// Handshake controller for the circular deque: accept, respond, idle.
module cdq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    output cdq_pkg::t_dp_cmd  o_cmd
);
    import cdq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RESP = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   in_acc;
    logic   is_idle;

    assign is_idle     = (r_state == S_IDLE);
    // a config write takes priority over an item in the same cycle
    assign in_acc      = is_idle && i_in_valid && !i_cfg_valid;
    assign o_in_stall  = !is_idle || i_cfg_valid;
    assign o_cfg_ready = is_idle;
    assign o_out_valid = (r_state == S_RESP);

    assign o_cmd.exec   = in_acc;
    assign o_cmd.cfg_wr = is_idle && i_cfg_valid;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // one item at a time: no new item while a result is pending
    a_no_accept_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("item accepted while a result is pending");

    // every accepted item yields a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("no result after an accepted item");

    // config and item commands never issue together
    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.exec && o_cmd.cfg_wr))
        else $error("execute and config write in the same cycle");

endmodule

FILE: rtl/core/cdq_dpath.sv
// Datapath for the circular deque: indices, capacity, entry store and result.
module cdq_dpath #(
    parameter int DEPTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cdq_pkg::t_dp_cmd              i_cmd,
    input  logic [cdq_pkg::CAP_W-1:0]     i_cfg_capacity,
    input  logic [1:0]                    i_req_type,
    input  logic signed [cdq_pkg::DATA_W-1:0] i_push_value,
    output logic [1:0]                    o_status,
    output logic signed [cdq_pkg::DATA_W-1:0] o_removed_value
);
    import cdq_pkg::*;

    localparam int AW   = $clog2(DEPTH);
    localparam int CAPW = (AW + 1 > CAP_W) ? AW + 1 : CAP_W;

    // capacity clamped to 1..DEPTH, kept as the last valid index
    function automatic logic [AW-1:0] cap_last(input logic [CAP_W-1:0] v);
        logic [CAPW-1:0] ext;
        ext = CAPW'(v);
        if (ext == '0) begin
            return '0;
        end else if (ext > CAPW'(DEPTH)) begin
            return AW'(DEPTH - 1);
        end else begin
            return AW'(ext - 1'b1);
        end
    endfunction

    localparam logic [AW-1:0] CAP_LAST_RST = cap_last(CAP_RESET);

    logic [AW-1:0] r_cap_last, n_cap_last;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic          r_empty, n_empty;
    logic [1:0]    r_status, n_status;
    logic          r_pop_ok, n_pop_ok;

    logic [AW-1:0]     head_up, head_dn, tail_up, tail_dn;
    logic              full;
    logic [AW-1:0]     slot;
    logic              ram_we, ram_re;
    logic [DATA_W-1:0] ram_rdata;

    // wrapped index steps
    assign head_up = (r_head == r_cap_last) ? '0 : r_head + 1'b1;
    assign head_dn = (r_head == '0) ? r_cap_last : r_head - 1'b1;
    assign tail_up = (r_tail == r_cap_last) ? '0 : r_tail + 1'b1;
    assign tail_dn = (r_tail == '0) ? r_cap_last : r_tail - 1'b1;
    assign full    = !r_empty && (tail_up == r_head);

    // request decode and index update
    always_comb begin
        n_cap_last = r_cap_last;
        n_head     = r_head;
        n_tail     = r_tail;
        n_empty    = r_empty;
        n_status   = r_status;
        n_pop_ok   = r_pop_ok;
        slot       = '0;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        if (i_cmd.cfg_wr) begin
            n_cap_last = cap_last(i_cfg_capacity);
            n_head     = '0;
            n_tail     = '0;
            n_empty    = 1'b1;
        end else if (i_cmd.exec) begin
            n_status = ST_DONE;
            n_pop_ok = 1'b0;
            case (i_req_type) inside
                REQ_PUSH_FRONT, REQ_PUSH_REAR: begin
                    if (full) begin
                        n_status = ST_OVERFLOW;
                    end else begin
                        ram_we = 1'b1;
                        if (r_empty) begin
                            n_head  = '0;
                            n_tail  = '0;
                            n_empty = 1'b0;
                            slot    = '0;
                        end else if (i_req_type == REQ_PUSH_FRONT) begin
                            n_head = head_dn;
                            slot   = head_dn;
                        end else begin
                            n_tail = tail_up;
                            slot   = tail_up;
                        end
                    end
                end
                REQ_POP_FRONT, REQ_POP_REAR: begin
                    if (r_empty) begin
                        n_status = ST_UNDERFLOW;
                    end else begin
                        ram_re   = 1'b1;
                        n_pop_ok = 1'b1;
                        slot     = (i_req_type == REQ_POP_FRONT) ? r_head : r_tail;
                        if (r_head == r_tail) begin
                            n_head  = '0;
                            n_tail  = '0;
                            n_empty = 1'b1;
                        end else if (i_req_type == REQ_POP_FRONT) begin
                            n_head = head_up;
                        end else begin
                            n_tail = tail_dn;
                        end
                    end
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_last <= CAP_LAST_RST;
            r_head     <= '0;
            r_tail     <= '0;
            r_empty    <= 1'b1;
        end else begin
            r_cap_last <= n_cap_last;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_empty    <= n_empty;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_pop_ok <= n_pop_ok;
    end

    // entry store
    cdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (slot),
        .i_wdata (DATA_W'(i_push_value)),
        .i_re    (ram_re),
        .i_raddr (slot),
        .o_rdata (ram_rdata)
    );

    assign o_status        = r_status;
    assign o_removed_value = r_pop_ok ? $signed(ram_rdata) : '0;

    // an empty deque has both indices parked at zero
    a_empty_parked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_empty |-> (r_head == '0 && r_tail == '0))
        else $error("empty deque with indices away from zero");

    // indices stay inside the active capacity
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_head <= r_cap_last) && (r_tail <= r_cap_last))
        else $error("index beyond active capacity");

    // the store is never written and read in the same cycle
    a_ram_one_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("store written and read together");

endmodule

FILE: rtl/core/circular_deque.sv
// Top level of the circular deque: ring-buffer double-ended queue of 32-bit items.
//
// Input channel (i_in_valid / o_in_stall) carries one request per item:
// i_req_type selects push front, push rear, pop front or pop rear, and
// i_push_value is the word stored by a push. Output channel (o_out_valid /
// i_out_stall) returns one result per request: o_status (done, overflow on
// a full push, underflow on an empty pop) and o_removed_value, the popped
// word or zero. Items move at clock edges where valid is high and stall low.
// Config channel (i_cfg_valid / o_cfg_ready) writes the capacity, clamped to
// 1..DEPTH; every write empties the deque. Write it only while idle.
// Latency: the result is valid in the cycle after the item is accepted.
// One item at a time: a new item is taken only after the last result is
// taken; the request and its result occupy the single controller loop in
// turn, and a pop reads the entry store through its registered read port.
// While the receiver stalls the result holds and no new item is taken.
// Reset (synchronous, active low) empties the deque and sets capacity to 16
// (or DEPTH if smaller); store contents are undefined until pushed.
module circular_deque #(
    parameter int DEPTH = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_req_type,
    input  logic signed [cdq_pkg::DATA_W-1:0] i_push_value,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [1:0]                        o_status,
    output logic signed [cdq_pkg::DATA_W-1:0] o_removed_value,
    // capacity register write
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cdq_pkg::CAP_W-1:0]         i_cfg_capacity
);
    import cdq_pkg::*;

    t_dp_cmd cmd;

    // handshake controller
    cdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (cmd)
    );

    // indices, store and result
    cdq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_cfg_capacity  (i_cfg_capacity),
        .i_req_type      (i_req_type),
        .i_push_value    (i_push_value),
        .o_status        (o_status),
        .o_removed_value (o_removed_value)
    );

endmodule
